// ----- src/dwsd_pkg.sv -----
// Shared types and constants for the distance window stuck detector.
// No dependencies; imported by every module of the block.
`default_nettype none

package dwsd_pkg;

  localparam int unsigned SampleW = 16;  // distance sample width
  localparam int unsigned DistW   = 15;  // distance thresholds
  localparam int unsigned CountW  = 7;   // count thresholds
  localparam int unsigned CntOutW = 6;   // reported zone count / drop run
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;
  localparam int unsigned RegIdxW = 3;

  // register indexes
  localparam logic [RegIdxW-1:0] REG_MAX_VALID = 3'd0;
  localparam logic [RegIdxW-1:0] REG_ZONE_LIM  = 3'd1;
  localparam logic [RegIdxW-1:0] REG_ZONE_MIN  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_RUN_REQ   = 3'd3;
  localparam logic [RegIdxW-1:0] REG_DROP      = 3'd4;

  // reset values
  localparam logic [DistW-1:0]  RST_MAX_VALID = 15'd200;
  localparam logic [DistW-1:0]  RST_ZONE_LIM  = 15'd35;
  localparam logic [CountW-1:0] RST_ZONE_MIN  = 7'd8;
  localparam logic [CountW-1:0] RST_RUN_REQ   = 7'd2;
  localparam logic [DistW-1:0]  RST_DROP      = 15'd3;

  // one window slot as seen by its neighbor and the evaluator
  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               vld;     // sample lies in 0..largest valid reading
  } cell_t;

  // pair evaluator controls
  typedef struct packed {
    logic clear;
    logic step;
  } eval_ctrl_t;

  // thresholds used by the pair evaluator
  typedef struct packed {
    logic [DistW-1:0] zone_limit;
    logic [DistW-1:0] drop_delta;
  } eval_cfg_t;

endpackage

`default_nettype wire

// ----- src/dwsd_cell.sv -----
// One slot of the sample window: holds a sample, loads from its neighbor
// when enabled and flags whether the held sample is a valid reading. Uses dwsd_pkg.
`default_nettype none

module dwsd_cell
  import dwsd_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [SampleW-1:0] d_i,
  input  logic [DistW-1:0]   max_valid_i,
  output cell_t              cell_o
);

  logic [SampleW-1:0] sample_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sample_q <= d_i;
    end
  end

  assign cell_o.sample = sample_q;
  assign cell_o.vld    = !sample_q[SampleW-1] && (sample_q[DistW-1:0] <= max_valid_i);

endmodule

`default_nettype wire

// ----- src/dwsd_pair_eval.sv -----
// Adjacent pair evaluator: accumulates the zone count and the trailing
// drop run over the pairs presented at the head of the cell chain. Uses dwsd_pkg.
`default_nettype none

module dwsd_pair_eval
  import dwsd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  eval_ctrl_t         ctrl_i,
  input  eval_cfg_t          cfg_i,
  input  cell_t              prev_i,
  input  cell_t              cur_i,
  output logic [CntOutW-1:0] zone_o,
  output logic [CntOutW-1:0] run_o
);

  logic [CntOutW-1:0] zone_q, zone_d;
  logic [CntOutW-1:0] run_q, run_d;
  logic [DistW-1:0]   prev_eff;
  logic [DistW+1:0]   diff;
  logic               is_drop;

  // invalid previous sample is replaced by the current one
  assign prev_eff = prev_i.vld ? prev_i.sample[DistW-1:0] : cur_i.sample[DistW-1:0];
  assign diff     = {2'b00, prev_eff} - {2'b00, cur_i.sample[DistW-1:0]};
  assign is_drop  = !diff[DistW+1] && (diff[DistW:0] >= {1'b0, cfg_i.drop_delta});

  always_comb begin
    zone_d = zone_q;
    run_d  = run_q;
    if (ctrl_i.clear) begin
      zone_d = '0;
      run_d  = '0;
    end else if (ctrl_i.step) begin
      if (!cur_i.vld) begin
        zone_d = zone_q + 1'b1;
      end else begin
        if (cur_i.sample[DistW-1:0] <= cfg_i.zone_limit) begin
          zone_d = zone_q + 1'b1;
        end
        run_d = is_drop ? run_q + 1'b1 : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= '0;
      run_q  <= '0;
    end else begin
      zone_q <= zone_d;
      run_q  <= run_d;
    end
  end

  assign zone_o = zone_q;
  assign run_o  = run_q;

endmodule

`default_nettype wire

// ----- src/distance_window_stuck_detector.sv -----
// Distance window stuck detector, top level: cell chain, pair evaluator,
// sequencer, APB register file and output register. Uses dwsd_pkg, dwsd_cell, dwsd_pair_eval.
//
// Usage: one signed 16-bit distance sample per item on the input channel
// (in_valid_i/in_ready_o); one result per item on the output channel
// (out_valid_o/out_ready_i): stuck latch, window_full, zone count, drop run.
// The window is a chain of WINDOW cells. An accepted item shifts into the
// chain. Once WINDOW samples are held, the chain rotates once per cycle
// through a full turn so each adjacent pair passes the evaluator at the chain
// head, one pair per cycle, and ends in its original order.
// When the window is full, an accepted item passes the evaluation rotation
// (ST_EVAL) and then ST_FIN; before that it goes straight to ST_FIN. The
// result is loaded into the output register from ST_FIN. One item is in
// work at a time; in_ready_o is high only while the sequencer is idle.
// A finished result sits in the output register; the next item is accepted
// while it waits. If the receiver stalls, the following result waits in the
// sequencer until the output register frees up.
// Reset clears the fill count, stuck latch and output register and loads register defaults.
// The user must write registers over APB only while idle; the block does not enforce it.
`default_nettype none

module distance_window_stuck_detector
  import dwsd_pkg::*;
#(
  parameter int unsigned WINDOW = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // sample input
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [SampleW-1:0] distance_i,
  // result output
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     stuck_o,
  output logic                     window_full_o,
  output logic [CntOutW-1:0]       zone_count_o,
  output logic [CntOutW-1:0]       drop_run_o,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [AddrW-1:0]         paddr,
  input  logic [DataW-1:0]         pwdata,
  output logic [DataW-1:0]         prdata,
  output logic                     pready
);

  localparam int unsigned FillW = $clog2(WINDOW + 1);
  localparam int unsigned RotW  = $clog2(WINDOW);
  localparam logic [FillW-1:0] FillFull = FillW'(WINDOW);
  localparam logic [RotW-1:0]  RotLast  = RotW'(WINDOW - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // ---------------- registers ----------------
  logic [DistW-1:0]  max_valid_q, zone_lim_q, drop_q;
  logic [CountW-1:0] zone_min_q, run_req_q;
  logic              cfg_wr;
  logic [RegIdxW-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_valid_q <= RST_MAX_VALID;
      zone_lim_q  <= RST_ZONE_LIM;
      zone_min_q  <= RST_ZONE_MIN;
      run_req_q   <= RST_RUN_REQ;
      drop_q      <= RST_DROP;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MAX_VALID: max_valid_q <= pwdata[DistW-1:0];
        REG_ZONE_LIM:  zone_lim_q  <= pwdata[DistW-1:0];
        REG_ZONE_MIN:  zone_min_q  <= pwdata[CountW-1:0];
        REG_RUN_REQ:   run_req_q   <= pwdata[CountW-1:0];
        REG_DROP:      drop_q      <= pwdata[DistW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MAX_VALID: prdata = {{(DataW-DistW){1'b0}}, max_valid_q};
      REG_ZONE_LIM:  prdata = {{(DataW-DistW){1'b0}}, zone_lim_q};
      REG_ZONE_MIN:  prdata = {{(DataW-CountW){1'b0}}, zone_min_q};
      REG_RUN_REQ:   prdata = {{(DataW-CountW){1'b0}}, run_req_q};
      REG_DROP:      prdata = {{(DataW-DistW){1'b0}}, drop_q};
      default:       prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  logic [1:0]       state_q, state_d;
  logic [RotW-1:0]  rot_q, rot_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             full_q, full_d;
  logic             stuck_q, stuck_d;
  logic             in_acc, out_load, chain_en;
  eval_ctrl_t       ectrl;

  logic                out_valid_q;
  logic                out_stuck_q, out_full_q;
  logic [CntOutW-1:0]  out_zone_q, out_run_q;
  logic [CntOutW-1:0]  zone_cnt, run_cnt;
  logic                stuck_hit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  assign chain_en   = in_acc || (state_q == ST_EVAL);

  assign ectrl.clear = in_acc;
  assign ectrl.step  = (state_q == ST_EVAL) && (rot_q != RotLast);

  assign stuck_hit = ({1'b0, zone_cnt} >= zone_min_q) && ({1'b0, run_cnt} < run_req_q);

  always_comb begin
    state_d = state_q;
    rot_d   = rot_q;
    fill_d  = fill_q;
    full_d  = full_q;
    stuck_d = stuck_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (fill_q != FillFull) begin
            fill_d = fill_q + 1'b1;
          end
          full_d  = (fill_d == FillFull);
          rot_d   = '0;
          state_d = (fill_d == FillFull) ? ST_EVAL : ST_FIN;
        end
      end
      ST_EVAL: begin
        rot_d = rot_q + 1'b1;
        if (rot_q == RotLast) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          if (full_q && stuck_hit) begin
            stuck_d = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rot_q   <= '0;
      fill_q  <= '0;
      full_q  <= 1'b0;
      stuck_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rot_q   <= rot_d;
      fill_q  <= fill_d;
      full_q  <= full_d;
      stuck_q <= stuck_d;
    end
  end

  // ---------------- cell chain ----------------
  cell_t cells [WINDOW];

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic [SampleW-1:0] cell_d;
    if (i == WINDOW - 1) begin : g_tail
      // tail takes the new item on a shift, the head's sample on a rotate
      assign cell_d = in_acc ? distance_i : cells[0].sample;
    end else begin : g_body
      assign cell_d = cells[i+1].sample;
    end
    dwsd_cell u_cell (
      .clk_i       (clk_i),
      .en_i        (chain_en),
      .d_i         (cell_d),
      .max_valid_i (max_valid_q),
      .cell_o      (cells[i])
    );
  end

  eval_cfg_t ecfg;
  assign ecfg.zone_limit = zone_lim_q;
  assign ecfg.drop_delta = drop_q;

  dwsd_pair_eval u_eval (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ectrl),
    .cfg_i  (ecfg),
    .prev_i (cells[0]),
    .cur_i  (cells[1]),
    .zone_o (zone_cnt),
    .run_o  (run_cnt)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_stuck_q <= 1'b0;
      out_full_q  <= 1'b0;
      out_zone_q  <= '0;
      out_run_q   <= '0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
      out_stuck_q <= stuck_q || (full_q && stuck_hit);
      out_full_q  <= full_q;
      out_zone_q  <= full_q ? zone_cnt : '0;
      out_run_q   <= full_q ? run_cnt : '0;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign stuck_o       = out_stuck_q;
  assign window_full_o = out_full_q;
  assign zone_count_o  = out_zone_q;
  assign drop_run_o    = out_run_q;

`ifndef SYNTHESIS
  // stuck is latched: once reported it never clears
  a_stuck_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stuck_o |=> stuck_o)
    else $error("stuck output cleared without reset");

  // no evaluation before the window fills
  a_not_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !window_full_o) |-> (zone_count_o == '0 && drop_run_o == '0))
    else $error("counts reported for a window that is not full");

  // a full result implies the fill count has saturated
  a_full_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && window_full_o) |-> (fill_q == FillFull))
    else $error("full result with unsaturated fill count");

  // the chain only moves while the sequencer evaluates or takes an item
  a_chain_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> !chain_en)
    else $error("cell chain moved while a result is pending");
`endif

endmodule

`default_nettype wire

// ----- tb/dwsd_checker.sv -----
// Checker for the distance window stuck detector: follows the APB writes and
// both item channels, predicts each result and compares it field by field.
// Depends on dwsd_pkg for widths, register indexes and reset values.
module dwsd_checker
  import dwsd_pkg::*;
#(
  parameter int unsigned WINDOW = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic signed [SampleW-1:0] distance_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic                      stuck_i,
  input  logic                      window_full_i,
  input  logic [CntOutW-1:0]        zone_count_i,
  input  logic [CntOutW-1:0]        drop_run_i,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic                      pready_i,
  input  logic [AddrW-1:0]          paddr_i,
  input  logic [DataW-1:0]          pwdata_i,
  input  logic                      end_i,
  output int                        fail_count_o
);

  typedef struct packed {
    logic               stuck;
    logic               window_full;
    logic [CntOutW-1:0] zone_count;
    logic [CntOutW-1:0] drop_run;
  } result_t;

  logic [DistW-1:0]          max_valid;
  logic [DistW-1:0]          zone_limit;
  logic [CountW-1:0]         zone_min;
  logic [CountW-1:0]         run_req;
  logic [DistW-1:0]          drop_delta;
  logic signed [SampleW-1:0] history [WINDOW];
  int unsigned               fill;
  logic                      stuck_seen;
  result_t                   pending_results [$];
  logic                      end_seen;

  function automatic logic in_range(int d);
    return d >= 0 && d <= int'(max_valid);
  endfunction

  // shift one sample in and walk the adjacent pairs, oldest first
  function automatic result_t shift_and_evaluate(logic signed [SampleW-1:0] d);
    result_t r;
    int      zone;
    int      run;
    int      cur;
    int      prev;
    r    = '0;
    zone = 0;
    run  = 0;
    for (int i = 0; i < WINDOW - 1; i++) history[i] = history[i+1];
    history[WINDOW-1] = d;
    if (fill < WINDOW) fill++;
    if (fill == WINDOW) begin
      for (int i = 1; i < WINDOW; i++) begin
        cur  = int'(history[i]);
        prev = int'(history[i-1]);
        if (!in_range(cur)) begin
          zone++;
          continue;
        end
        if (!in_range(prev)) prev = cur;
        if (cur <= int'(zone_limit)) zone++;
        if (prev - cur >= int'(drop_delta)) run++;
        else run = 0;
      end
      if (zone >= int'(zone_min) && run < int'(run_req)) stuck_seen = 1'b1;
      r.window_full = 1'b1;
      r.zone_count  = zone[CntOutW-1:0];
      r.drop_run    = run[CntOutW-1:0];
    end
    r.stuck = stuck_seen;
    return r;
  endfunction

  task automatic check_field(string name, int want, logic [CntOutW-1:0] got);
    if (got !== want[CntOutW-1:0]) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_valid  = RST_MAX_VALID;
      zone_limit = RST_ZONE_LIM;
      zone_min   = RST_ZONE_MIN;
      run_req    = RST_RUN_REQ;
      drop_delta = RST_DROP;
      fill       = 0;
      stuck_seen = 1'b0;
      pending_results.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[AddrW-1:2])
          REG_MAX_VALID: max_valid  = pwdata_i[DistW-1:0];
          REG_ZONE_LIM:  zone_limit = pwdata_i[DistW-1:0];
          REG_ZONE_MIN:  zone_min   = pwdata_i[CountW-1:0];
          REG_RUN_REQ:   run_req    = pwdata_i[CountW-1:0];
          REG_DROP:      drop_delta = pwdata_i[DistW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        pending_results.insert(pending_results.size(), shift_and_evaluate(distance_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result item with no sample pending");
          fail_count_o++;
        end else begin
          check_field("stuck", pending_results[0].stuck, CntOutW'(stuck_i));
          check_field("window_full", pending_results[0].window_full,
                      CntOutW'(window_full_i));
          check_field("zone_count", pending_results[0].zone_count, zone_count_i);
          check_field("drop_run", pending_results[0].drop_run, drop_run_i);
          if (stuck_i === 1'bx || window_full_i === 1'bx) begin
            $error("stuck/window_full: expected known, actual x");
            fail_count_o++;
          end
          pending_results.delete(0);
        end
      end
    end
  end

  initial begin
    fail_count_o = 0;
    end_seen     = 1'b0;
  end

  always @(posedge clk_i) begin
    if (end_i && !end_seen) begin
      end_seen = 1'b1;
      if (pending_results.size() != 0) begin
        $error("%0d expected results never arrived", pending_results.size());
        fail_count_o++;
      end
    end
  end

endmodule

// ----- tb/distance_window_stuck_detector_tb.sv -----
// Testbench top for the distance window stuck detector: clock, reset, APB
// setup per phase, sample stimulus and output stalls. Uses dwsd_pkg and
// dwsd_checker, which predicts and compares every result item.
module distance_window_stuck_detector_tb;
  import dwsd_pkg::*;

  localparam int unsigned WINDOW = 16;
  localparam logic [RegIdxW-1:0] REG_UNUSED = 3'd7;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [SampleW-1:0] distance_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic                      stuck_o;
  logic                      window_full_o;
  logic [CntOutW-1:0]        zone_count_o;
  logic [CntOutW-1:0]        drop_run_o;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [AddrW-1:0]          paddr;
  logic [DataW-1:0]          pwdata;
  logic [DataW-1:0]          prdata;
  logic                      pready;
  logic                      end_i;
  int                        fail_count;

  int                        items_sent;
  int                        results_seen;
  logic                      no_idle;
  // stimulus view of the current thresholds and the approach trend
  int                        cur_max;
  int                        cur_zlim;
  int                        cur_delta;
  int                        trend;

  always #10 clk_i = ~clk_i;

  distance_window_stuck_detector #(.WINDOW(WINDOW)) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .distance_i,
    .out_valid_o, .out_ready_i, .stuck_o, .window_full_o, .zone_count_o, .drop_run_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  dwsd_checker #(.WINDOW(WINDOW)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .distance_i,
    .out_valid_i(out_valid_o), .out_ready_i, .stuck_i(stuck_o),
    .window_full_i(window_full_o), .zone_count_i(zone_count_o), .drop_run_i(drop_run_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata), .end_i, .fail_count_o(fail_count)
  );

  always @(posedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(99) >= 24);
    if (rst_ni && out_valid_o && out_ready_i) results_seen++;
  end

  // upper data bits are random; the register keeps only its own width
  task automatic write_reg(logic [RegIdxW-1:0] idx, int unsigned value, int unsigned width);
    logic [DataW-1:0] data;
    data = $urandom();
    data = ((data >> width) << width) | value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic configure(int max_d, int zlim, int zmin, int rreq, int delta);
    write_reg(REG_MAX_VALID, max_d, DistW);
    write_reg(REG_ZONE_LIM, zlim, DistW);
    write_reg(REG_ZONE_MIN, zmin, CountW);
    write_reg(REG_RUN_REQ, rreq, CountW);
    write_reg(REG_DROP, delta, DistW);
    if ($urandom_range(1)) write_reg(REG_UNUSED, $urandom(), DataW - 1);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    cur_max   = max_d;
    cur_zlim  = zlim;
    cur_delta = delta;
    trend     = -1;
  endtask

  // called at a clock edge; valid stays up when the next sample follows at once
  task automatic send_sample(logic signed [SampleW-1:0] d);
    while (!no_idle && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    distance_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (results_seen != items_sent) @(posedge clk_i);
  endtask

  // mostly an obstacle coming closer, plus flat stretches, edges and noise
  function automatic logic signed [SampleW-1:0] next_distance();
    int kind;
    int v;
    kind = $urandom_range(99);
    if (kind < 55) begin
      if (trend < 0 || $urandom_range(15) == 0) trend = $urandom_range(cur_max);
      trend = trend - (cur_delta + $urandom_range(2) - 1);
      if (trend < -32768) trend = -32768;
      v = trend;
    end else if (kind < 72) begin
      v = $urandom_range(cur_zlim + 3);
    end else if (kind < 82) begin
      v = (trend < 0) ? 0 : trend;
    end else if (kind < 92) begin
      case ($urandom_range(7))
        0: v = 0;
        1: v = cur_max;
        2: v = cur_max + 1;
        3: v = cur_zlim;
        4: v = cur_zlim + 1;
        5: v = -1;
        6: v = 32767;
        default: v = -32768;
      endcase
    end else begin
      v = $urandom();
    end
    return SampleW'(v);
  endfunction

  task automatic random_phase(int count);
    repeat (count) send_sample(next_distance());
    drain();
  endtask

  initial begin
    logic signed [SampleW-1:0] directed [25] = '{
      200, 201, 32767, -32768, -1, 0, 35, 36, 100, 97, 94, 94, 90,
      50, 47, 44, 41, 38, 35, 32, 29, -5, 29, 26, 20
    };
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    distance_i   <= '0;
    out_ready_i  <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    end_i        <= 1'b0;
    items_sent   = 0;
    results_seen = 0;
    no_idle      = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // stuck held off by an unreachable zone count
    configure(200, 35, 64, 64, 3);
    foreach (directed[i]) send_sample(directed[i]);
    drain();

    // widest valid range, zero drop delta
    configure(32767, 32767, 64, 0, 0);
    random_phase(120);

    // only zero is valid, largest drop delta
    configure(0, 0, 0, 0, 32767);
    random_phase(100);

    no_idle = 1'b1;
    configure(1000, 100, 16, 5, 7);
    random_phase(150);
    no_idle = 1'b0;

    // reset thresholds; stuck is expected to latch here
    configure(200, 35, 8, 2, 3);
    random_phase(150);

    configure(5000, 400, 3, 64, 1);
    random_phase(80);

    repeat (WINDOW + 4) @(posedge clk_i);
    end_i <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
